/* design/boff_pkg.sv */
// Shared constants, types and register codes of the broadcast offset generator.
package boff_pkg;

    localparam int MAX_DIMS       = 4;
    localparam int DIM_BITS       = 16;
    localparam int IDX_BITS       = 32;
    localparam int OFF_BITS       = 34;
    localparam int RANK_BITS      = 3;
    localparam int CFG_IDX_BITS   = 3;
    localparam int CFG_DATA_BITS  = MAX_DIMS * DIM_BITS;
    localparam int DIM_IDX_BITS   = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;

    // Each division stage retires this many quotient bits.
    localparam int BITS_PER_STAGE = 4;
    localparam int STAGES_PER_DIM = IDX_BITS / BITS_PER_STAGE;
    localparam int NUM_DIV_STAGES = MAX_DIMS * STAGES_PER_DIM;

    localparam int PROD_BITS      = 2 * DIM_BITS;
    localparam int PAIR_BITS      = PROD_BITS + 1;
    // The offset adder tree is built for the largest supported dimension count.
    localparam int SUM_TERMS      = 4;

    localparam logic [CFG_IDX_BITS-1:0] CFG_FIRST_RANK   = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_SECOND_RANK  = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_FIRST_SIZES  = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] CFG_SECOND_SIZES = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] CFG_FIRST_STEPS  = 3'd4;
    localparam logic [CFG_IDX_BITS-1:0] CFG_SECOND_STEPS = 3'd5;

    typedef struct packed {
        logic [DIM_BITS-1:0] big;
        logic                en_first;
        logic                en_second;
        logic [DIM_BITS-1:0] step_first;
        logic [DIM_BITS-1:0] step_second;
    } t_dim_info;

    typedef struct packed {
        t_dim_info [MAX_DIMS-1:0] dim;
        logic                     ok;
    } t_bcast_cfg;

    typedef struct packed {
        logic [IDX_BITS-1:0]                numq;
        logic [DIM_BITS-1:0]                rem;
        logic [MAX_DIMS-1:0][DIM_BITS-1:0] coord;
    } t_lane;

endpackage

/* design/broadcast_offset_generator.sv */
// Top level: maps a flat index of a broadcast result to offsets into two operands.
//
//  channel  | handshake            | payload
//  ---------+----------------------+---------------------------------------------
//  command  | start, busy          | i_flat_index
//  result   | o_strobe (one cycle) | o_first_offset, o_second_offset,
//           |                      | o_shapes_compatible
//  config   | i_cfg_we             | i_cfg_idx, i_cfg_data
//
// One index is accepted every cycle while busy is low. The pipeline depth is set
// by the divider chain: four quotient bits per stage, eight stages per dimension,
// four dimensions, then multiply and two adder levels.
// busy is high for one cycle after reset and after every configuration write,
// while the divisor and stride table is re-registered. The receiver cannot stall,
// so the pipeline never holds; synchronous reset clears every valid bit.
module broadcast_offset_generator (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               start,
    output logic                               busy,
    input  logic [boff_pkg::IDX_BITS-1:0]      i_flat_index,
    output logic                               o_strobe,
    output logic [boff_pkg::OFF_BITS-1:0]      o_first_offset,
    output logic [boff_pkg::OFF_BITS-1:0]      o_second_offset,
    output logic                               o_shapes_compatible,
    input  logic                               i_cfg_we,
    input  logic [boff_pkg::CFG_IDX_BITS-1:0]  i_cfg_idx,
    input  logic [boff_pkg::CFG_DATA_BITS-1:0] i_cfg_data
);
    import boff_pkg::*;

    t_bcast_cfg                         cfg;
    logic                               stage_valid [NUM_DIV_STAGES];
    t_lane                              stage_out [NUM_DIV_STAGES];
    logic [MAX_DIMS-1:0][DIM_BITS-1:0] done_coord;

    boff_dim_table u_dim_table (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_busy     (busy),
        .o_cfg      (cfg)
    );

    for (genvar g = 0; g < NUM_DIV_STAGES; g++) begin : g_div
        t_lane lane_in;
        logic  valid_in;

        if (g == 0) begin : g_entry
            always_comb begin
                lane_in      = '0;
                lane_in.numq = i_flat_index;
                valid_in     = start && !busy;
            end
        end else if ((g % STAGES_PER_DIM) == 0) begin : g_next_dim
            // The remainder of the finished dimension is its coordinate; the
            // quotient carries on as the dividend of the next dimension.
            always_comb begin
                lane_in = stage_out[g-1];
                lane_in.coord[g/STAGES_PER_DIM-1] = stage_out[g-1].rem;
                lane_in.rem = '0;
                valid_in    = stage_valid[g-1];
            end
        end else begin : g_chain
            always_comb begin
                lane_in  = stage_out[g-1];
                valid_in = stage_valid[g-1];
            end
        end

        boff_div_stage u_stage (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_valid   (valid_in),
            .i_lane    (lane_in),
            .i_divisor (cfg.dim[g/STAGES_PER_DIM].big),
            .o_valid   (stage_valid[g]),
            .o_lane    (stage_out[g])
        );
    end

    always_comb begin
        done_coord = stage_out[NUM_DIV_STAGES-1].coord;
        done_coord[MAX_DIMS-1] = stage_out[NUM_DIV_STAGES-1].rem;
    end

    boff_offset_sum u_offset_sum (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_valid             (stage_valid[NUM_DIV_STAGES-1]),
        .i_coord             (done_coord),
        .i_cfg               (cfg),
        .o_strobe            (o_strobe),
        .o_first_offset      (o_first_offset),
        .o_second_offset     (o_second_offset),
        .o_shapes_compatible (o_shapes_compatible)
    );

endmodule

/* design/boff_dim_table.sv */
// Configuration registers and the registered per-dimension divisor and stride table.
module boff_dim_table (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [boff_pkg::CFG_IDX_BITS-1:0]  i_cfg_idx,
    input  logic [boff_pkg::CFG_DATA_BITS-1:0] i_cfg_data,
    output logic                              o_busy,
    output boff_pkg::t_bcast_cfg              o_cfg
);
    import boff_pkg::*;

    logic [RANK_BITS-1:0]     r_first_rank;
    logic [RANK_BITS-1:0]     r_second_rank;
    logic [CFG_DATA_BITS-1:0] r_first_sizes;
    logic [CFG_DATA_BITS-1:0] r_second_sizes;
    logic [CFG_DATA_BITS-1:0] r_first_steps;
    logic [CFG_DATA_BITS-1:0] r_second_steps;
    logic                     r_settle;
    t_bcast_cfg               r_cfg;
    t_bcast_cfg               n_cfg;

    logic [RANK_BITS-1:0]    rank_a;
    logic [RANK_BITS-1:0]    rank_b;
    logic                    has_a;
    logic                    has_b;
    logic [DIM_IDX_BITS-1:0] dim_a;
    logic [DIM_IDX_BITS-1:0] dim_b;
    logic [DIM_BITS-1:0]     field_a;
    logic [DIM_BITS-1:0]     field_b;
    logic [DIM_BITS-1:0]     size_a;
    logic [DIM_BITS-1:0]     size_b;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_first_rank   <= RANK_BITS'(1);
            r_second_rank  <= RANK_BITS'(1);
            r_first_sizes  <= CFG_DATA_BITS'(1);
            r_second_sizes <= CFG_DATA_BITS'(1);
            r_first_steps  <= CFG_DATA_BITS'(1);
            r_second_steps <= CFG_DATA_BITS'(1);
            r_settle       <= 1'b1;
        end else begin
            r_settle <= i_cfg_we;
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_FIRST_RANK:   r_first_rank   <= i_cfg_data[RANK_BITS-1:0];
                    CFG_SECOND_RANK:  r_second_rank  <= i_cfg_data[RANK_BITS-1:0];
                    CFG_FIRST_SIZES:  r_first_sizes  <= i_cfg_data;
                    CFG_SECOND_SIZES: r_second_sizes <= i_cfg_data;
                    CFG_FIRST_STEPS:  r_first_steps  <= i_cfg_data;
                    CFG_SECOND_STEPS: r_second_steps <= i_cfg_data;
                    default: ;
                endcase
            end
        end
    end

    // Entry k describes the k-th dimension counted from the trailing end. A missing
    // dimension reads as size 1, so the divisor comes from the other operand and its stride is unused.
    always_comb begin
        rank_a = (r_first_rank > RANK_BITS'(MAX_DIMS)) ? RANK_BITS'(MAX_DIMS) : r_first_rank;
        rank_b = (r_second_rank > RANK_BITS'(MAX_DIMS)) ? RANK_BITS'(MAX_DIMS) : r_second_rank;
        n_cfg = '0;
        n_cfg.ok = 1'b1;
        for (int k = 0; k < MAX_DIMS; k++) begin
            has_a = RANK_BITS'(k) < rank_a;
            has_b = RANK_BITS'(k) < rank_b;
            dim_a = has_a ? DIM_IDX_BITS'(rank_a - RANK_BITS'(k) - RANK_BITS'(1)) : '0;
            dim_b = has_b ? DIM_IDX_BITS'(rank_b - RANK_BITS'(k) - RANK_BITS'(1)) : '0;
            field_a = r_first_sizes[dim_a*DIM_BITS +: DIM_BITS];
            field_b = r_second_sizes[dim_b*DIM_BITS +: DIM_BITS];
            size_a = (has_a && (field_a != '0)) ? field_a : DIM_BITS'(1);
            size_b = (has_b && (field_b != '0)) ? field_b : DIM_BITS'(1);
            n_cfg.dim[k].big         = (size_a > size_b) ? size_a : size_b;
            n_cfg.dim[k].en_first    = size_a > DIM_BITS'(1);
            n_cfg.dim[k].en_second   = size_b > DIM_BITS'(1);
            n_cfg.dim[k].step_first  = r_first_steps[dim_a*DIM_BITS +: DIM_BITS];
            n_cfg.dim[k].step_second = r_second_steps[dim_b*DIM_BITS +: DIM_BITS];
            if ((size_a != size_b) && (size_a != DIM_BITS'(1)) && (size_b != DIM_BITS'(1))) begin
                n_cfg.ok = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_cfg <= n_cfg;
    end

    // The table follows the registers in the next cycle, so new work waits for it.
    assign o_busy = r_settle;
    assign o_cfg  = r_cfg;

endmodule

/* design/boff_div_stage.sv */
// One pipeline stage of the restoring divider, retiring BITS_PER_STAGE (four) quotient bits.
module boff_div_stage (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    input  boff_pkg::t_lane               i_lane,
    input  logic [boff_pkg::DIM_BITS-1:0] i_divisor,
    output logic                          o_valid,
    output boff_pkg::t_lane               o_lane
);
    import boff_pkg::*;

    logic                r_valid;
    t_lane               r_lane;
    t_lane               n_lane;
    logic [DIM_BITS:0]   trial;

    // The dividend bits leave the top of numq while quotient bits enter at the
    // bottom; rem stays below the divisor after every step.
    always_comb begin
        n_lane = i_lane;
        for (int b = 0; b < BITS_PER_STAGE; b++) begin
            trial = {n_lane.rem, n_lane.numq[IDX_BITS-1]};
            if (trial >= {1'b0, i_divisor}) begin
                n_lane.rem  = DIM_BITS'(trial - {1'b0, i_divisor});
                n_lane.numq = {n_lane.numq[IDX_BITS-2:0], 1'b1};
            end else begin
                n_lane.rem  = trial[DIM_BITS-1:0];
                n_lane.numq = {n_lane.numq[IDX_BITS-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_lane <= n_lane;
    end

    assign o_valid = r_valid;
    assign o_lane  = r_lane;

endmodule

/* design/boff_offset_sum.sv */
// Stride multipliers and the two-level adder tree that form both operand offsets.
module boff_offset_sum (
    input  logic                                             i_clk,
    input  logic                                             i_rst_n,
    input  logic                                             i_valid,
    input  logic [boff_pkg::MAX_DIMS-1:0][boff_pkg::DIM_BITS-1:0] i_coord,
    input  boff_pkg::t_bcast_cfg                             i_cfg,
    output logic                                             o_strobe,
    output logic [boff_pkg::OFF_BITS-1:0]                    o_first_offset,
    output logic [boff_pkg::OFF_BITS-1:0]                    o_second_offset,
    output logic                                             o_shapes_compatible
);
    import boff_pkg::*;

    logic                 r_prod_valid;
    logic                 r_pair_valid;
    logic                 r_strobe;
    logic [PROD_BITS-1:0] r_prod_a [MAX_DIMS];
    logic [PROD_BITS-1:0] r_prod_b [MAX_DIMS];
    logic [PROD_BITS-1:0] pad_a [SUM_TERMS];
    logic [PROD_BITS-1:0] pad_b [SUM_TERMS];
    logic [PAIR_BITS-1:0] r_pair_a [2];
    logic [PAIR_BITS-1:0] r_pair_b [2];
    logic [OFF_BITS-1:0]  r_first_offset;
    logic [OFF_BITS-1:0]  r_second_offset;
    logic                 r_ok;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prod_valid <= 1'b0;
            r_pair_valid <= 1'b0;
            r_strobe     <= 1'b0;
        end else begin
            r_prod_valid <= i_valid;
            r_pair_valid <= r_prod_valid;
            r_strobe     <= r_pair_valid;
        end
    end

    // A coordinate only counts toward an operand whose own size there exceeds 1.
    always_ff @(posedge i_clk) begin
        for (int k = 0; k < MAX_DIMS; k++) begin
            r_prod_a[k] <= i_cfg.dim[k].en_first ?
                           PROD_BITS'(i_coord[k]) * PROD_BITS'(i_cfg.dim[k].step_first) : '0;
            r_prod_b[k] <= i_cfg.dim[k].en_second ?
                           PROD_BITS'(i_coord[k]) * PROD_BITS'(i_cfg.dim[k].step_second) : '0;
        end
    end

    always_comb begin
        for (int k = 0; k < SUM_TERMS; k++) begin
            pad_a[k] = '0;
            pad_b[k] = '0;
        end
        for (int k = 0; k < MAX_DIMS; k++) begin
            pad_a[k] = r_prod_a[k];
            pad_b[k] = r_prod_b[k];
        end
    end

    always_ff @(posedge i_clk) begin
        r_pair_a[0] <= PAIR_BITS'(pad_a[0]) + PAIR_BITS'(pad_a[1]);
        r_pair_a[1] <= PAIR_BITS'(pad_a[2]) + PAIR_BITS'(pad_a[3]);
        r_pair_b[0] <= PAIR_BITS'(pad_b[0]) + PAIR_BITS'(pad_b[1]);
        r_pair_b[1] <= PAIR_BITS'(pad_b[2]) + PAIR_BITS'(pad_b[3]);
    end

    always_ff @(posedge i_clk) begin
        r_first_offset  <= OFF_BITS'({1'b0, r_pair_a[0]} + {1'b0, r_pair_a[1]});
        r_second_offset <= OFF_BITS'({1'b0, r_pair_b[0]} + {1'b0, r_pair_b[1]});
        r_ok            <= i_cfg.ok;
    end

    assign o_strobe            = r_strobe;
    assign o_first_offset      = r_first_offset;
    assign o_second_offset     = r_second_offset;
    assign o_shapes_compatible = r_ok;

endmodule
